// ===== rtl/pcmat_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM audio port package
// Shared types and constants for the PCM port and its interval timer.
// ----------------------------------------------------------------------------
package pcmat_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  localparam int unsigned NumCh   = 3;
  localparam int unsigned CntW    = 18;
  localparam int unsigned RelW    = 17;
  localparam logic [CntW-1:0] CntAllOnes = '1;
  localparam logic [RelW-1:0] RelMax     = 17'h10000;

  // One input beat as presented on the input ports.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] reg_offset;
    logic [7:0]  write_byte;
    logic [7:0]  dma_first;
    logic [7:0]  dma_second;
  } item_t;

  // Timer view passed between the timer and the top level.
  typedef struct packed {
    logic        tick_en;
    logic        wide;
    logic        ch1_fetch;
  } tmr_ctl_t;

  typedef struct packed {
    logic        ch0_expired;
    logic        ch1_running;
    logic        ch1_expired;
  } tmr_sts_t;

endpackage

// ===== rtl/pcmat_timer.sv =====
// ----------------------------------------------------------------------------
// Interval timer
// Three channel timer with latch, low, high and low-then-high access modes.
// ----------------------------------------------------------------------------
module pcmat_timer import pcmat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_i,
  input  logic        rd_i,
  input  logic [1:0]  sel_i,
  input  logic [7:0]  data_i,
  input  tmr_ctl_t    ctl_i,
  output tmr_sts_t    sts_o,
  output logic [7:0]  rdata_o
);

  logic [RelW-1:0] reload_q [NumCh];
  logic [RelW-1:0] reload_d [NumCh];
  logic [CntW-1:0] count_q  [NumCh];
  logic [CntW-1:0] count_d  [NumCh];
  logic [2:0]      mode_q   [NumCh];
  logic [2:0]      mode_d   [NumCh];
  logic [1:0]      rph_q    [NumCh];
  logic [1:0]      rph_d    [NumCh];
  logic [1:0]      wph_q    [NumCh];
  logic [1:0]      wph_d    [NumCh];
  logic [15:0]     latch_q  [NumCh];
  logic [15:0]     latch_d  [NumCh];
  logic [NumCh-1:0] relatch_q, relatch_d, run_q, run_d;
  logic [7:0]      ctrl_q, ctrl_d;

  logic [1:0]      ch;
  logic [2:0]      m;
  logic [15:0]     lv;
  logic [CntW-1:0] c0, c1, rl0, rl1;

  always_comb begin
    reload_d  = reload_q;
    count_d   = count_q;
    mode_d    = mode_q;
    rph_d     = rph_q;
    wph_d     = wph_q;
    latch_d   = latch_q;
    relatch_d = relatch_q;
    run_d     = run_q;
    ctrl_d    = ctrl_q;
    rdata_o   = 8'hFF;
    sts_o     = '0;
    ch        = data_i[7:6];
    m         = data_i[3:1];
    lv        = '0;
    c0        = '0;
    c1        = '0;
    rl0       = '0;
    rl1       = '0;

    if (wr_i) begin
      if (sel_i == 2'd3) begin
        if (data_i[7:6] == 2'b11) begin
          if (!data_i[5]) begin
            for (int k = 0; k < NumCh; k++) begin
              if (data_i[k+1]) latch_d[k] = count_q[k][15:0];
            end
          end
        end else begin
          ctrl_d = data_i;
          if (data_i[5:4] == 2'b00) begin
            latch_d[ch] = count_q[ch][RelW] ? 16'h0 : count_q[ch][15:0];
            ctrl_d = data_i | 8'h30;
            relatch_d[ch] = 1'b0;
            rph_d[ch] = 2'd3;
          end else begin
            if (m > 3'd5) m = {1'b0, m[1:0]};
            rph_d[ch] = data_i[5:4];
            wph_d[ch] = data_i[5:4];
            mode_d[ch] = m;
            relatch_d[ch] = 1'b1;
          end
        end
      end else begin
        case (wph_q[sel_i])
          2'd1: begin
            reload_d[sel_i] = {9'd0, data_i};
            count_d[sel_i]  = {10'd0, data_i};
            run_d[sel_i]    = 1'b1;
          end
          2'd2: begin
            reload_d[sel_i] = {1'b0, data_i, 8'd0};
            count_d[sel_i]  = {2'd0, data_i, 8'd0};
            run_d[sel_i]    = 1'b1;
          end
          2'd0: begin
            reload_d[sel_i] = {1'b0, data_i, reload_q[sel_i][7:0]};
            count_d[sel_i]  = {2'd0, data_i, reload_q[sel_i][7:0]};
            wph_d[sel_i]    = 2'd3;
            run_d[sel_i]    = 1'b1;
          end
          default: begin
            reload_d[sel_i] = {1'b0, reload_q[sel_i][15:8], data_i};
            wph_d[sel_i]    = 2'd0;
          end
        endcase
        if (reload_d[sel_i] == '0) begin
          reload_d[sel_i] = RelMax;
          count_d[sel_i]  = {1'b0, RelMax};
        end
      end
    end

    if (rd_i) begin
      if (sel_i == 2'd3) begin
        rdata_o = ctrl_q;
      end else begin
        lv = latch_q[sel_i];
        if (relatch_q[sel_i]) begin
          relatch_d[sel_i] = 1'b0;
          if (!count_q[sel_i][RelW] && count_q[sel_i] > {1'b0, RelMax}) lv = 16'hFFFF;
          else lv = count_q[sel_i][15:0];
        end
        latch_d[sel_i] = lv;
        case (rph_q[sel_i])
          2'd0: begin
            rdata_o = lv[15:8];
            rph_d[sel_i] = 2'd3;
            relatch_d[sel_i] = 1'b1;
          end
          2'd1: begin
            rdata_o = lv[7:0];
            relatch_d[sel_i] = 1'b1;
          end
          2'd2: begin
            rdata_o = lv[15:8];
            relatch_d[sel_i] = 1'b1;
          end
          default: begin
            rdata_o = lv[7:0];
            rph_d[sel_i] = 2'd0;
          end
        endcase
      end
    end

    if (ctl_i.tick_en && run_q[0]) begin
      c0 = count_q[0] - 18'd1;
      count_d[0] = c0;
      if (c0 == '0) begin
        sts_o.ch0_expired = 1'b1;
        if (mode_q[0][1]) begin
          rl0 = (reload_q[0] == '0) ? {1'b0, RelMax} : {1'b0, reload_q[0]};
          count_d[0] = rl0;
        end else begin
          count_d[0] = CntAllOnes;
          run_d[0] = 1'b0;
        end
        sts_o.ch1_running = run_q[1];
        if (run_q[1]) begin
          c1 = count_q[1] - (ctl_i.wide ? 18'd2 : 18'd1);
          count_d[1] = c1;
          if (c1 == '0) begin
            sts_o.ch1_expired = 1'b1;
            if (mode_q[1][1]) begin
              rl1 = (reload_q[1] == '0) ? {1'b0, RelMax} : {1'b0, reload_q[1]};
              count_d[1] = rl1;
            end else begin
              count_d[1] = CntAllOnes;
              run_d[1] = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumCh; k++) begin
        reload_q[k] <= '0;
        count_q[k]  <= '0;
        mode_q[k]   <= '0;
        rph_q[k]    <= '0;
        wph_q[k]    <= '0;
        latch_q[k]  <= '0;
      end
      relatch_q <= '0;
      run_q     <= '0;
      ctrl_q    <= '0;
    end else begin
      reload_q  <= reload_d;
      count_q   <= count_d;
      mode_q    <= mode_d;
      rph_q     <= rph_d;
      wph_q     <= wph_d;
      latch_q   <= latch_d;
      relatch_q <= relatch_d;
      run_q     <= run_d;
      ctrl_q    <= ctrl_d;
    end
  end

  // ctl_i.ch1_fetch is informational for the caller; channel 1 owns its count.
  logic unused_fetch;
  assign unused_fetch = ctl_i.ch1_fetch;

`ifndef SYNTHESIS
  a_ch1_needs_ch0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.ch1_expired |-> sts_o.ch0_expired) else $error("ch1 expired without ch0");
  a_ch0_needs_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_o.ch0_expired |-> ctl_i.tick_en) else $error("ch0 expired without tick");
  a_oneshot_stops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sts_o.ch0_expired && !mode_q[0][1]) |=> !run_q[0]) else $error("one-shot kept running");
`endif

endmodule

// ===== rtl/pcm_audio_port_with_interval_timers_top.sv =====
// ----------------------------------------------------------------------------
// PCM audio port with interval timers
// Each accepted beat's result is registered in the output or skid register.
// Throughput: one beat per cycle; an output register with a skid stage
// decouples the two sides, so the input stalls only when both hold data.
// Reset: asynchronous, active low; every register and timer channel clears.
// ----------------------------------------------------------------------------
module pcm_audio_port_with_interval_timers_top import pcmat_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         opcode_i,
  input  logic [15:0]        reg_offset_i,
  input  logic [7:0]         write_byte_i,
  input  logic [7:0]         dma_first_i,
  input  logic [7:0]         dma_second_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         read_byte_o,
  output logic               irq_pulse_o,
  output logic [1:0]         dma_used_o,
  output logic signed [15:0] left_sample_o,
  output logic signed [15:0] right_sample_o
);

  typedef struct packed {
    logic [7:0]  rd;
    logic        irq;
    logic [1:0]  used;
    logic [15:0] left;
    logic [15:0] right;
  } res_t;

  logic       acc;
  logic       wr, rd, tick;
  logic [15:0] a;
  logic [7:0] v;

  logic [7:0]  mixer_q, mixer_d, status_q, status_d, filter_q, filter_d;
  logic [7:0]  mask_q, mask_d, pcmctl_q, pcmctl_d;
  logic [15:0] direct_q, direct_d, left_q, left_d, right_q, right_d;
  logic [7:0]  setup_q [12];
  logic [7:0]  setup_d [12];
  logic        tog_q, tog_d;

  logic        tmr_sel;
  tmr_ctl_t    tctl;
  tmr_sts_t    tsts;
  logic [7:0]  trd;
  logic [15:0] s;
  res_t        res;

  logic        o_vld_q, sk_vld_q;
  res_t        o_q, sk_q;

  assign in_stall_o = sk_vld_q;
  assign acc  = in_valid_i && !in_stall_o;
  assign wr   = acc && (opcode_i == OP_WRITE);
  assign rd   = acc && (opcode_i == OP_READ);
  assign tick = acc && (opcode_i == OP_TICK);
  assign a    = reg_offset_i;
  assign v    = write_byte_i;
  assign tmr_sel = (a >= 16'h1388) && (a <= 16'h138B);

  assign tctl.tick_en   = tick;
  assign tctl.wide      = setup_q[2][2];
  assign tctl.ch1_fetch = pcmctl_q[6];

  pcmat_timer u_timer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr && tmr_sel),
    .rd_i    (rd && tmr_sel),
    .sel_i   (a[1:0]),
    .data_i  (v),
    .ctl_i   (tctl),
    .sts_o   (tsts),
    .rdata_o (trd)
  );

  always_comb begin
    mixer_d = mixer_q; status_d = status_q; filter_d = filter_q;
    mask_d = mask_q; pcmctl_d = pcmctl_q; direct_d = direct_q;
    left_d = left_q; right_d = right_q; setup_d = setup_q; tog_d = tog_q;
    res = '0;
    s = '0;

    if (wr && !tmr_sel) begin
      case (a)
        16'h0B88: mixer_d = v;
        16'h0B89: status_d = status_q & ~v;
        16'h0B8A: filter_d = v;
        16'h0B8B: mask_d = v;
        16'h0F88: direct_d = {direct_q[15:8], v};
        16'h0F89: direct_d = {v, direct_q[7:0]};
        16'h0F8A: begin
          if (v[6] && !pcmctl_q[6]) tog_d = 1'b0;
          pcmctl_d = v;
        end
        16'h7F89: setup_d[0] = v;
        16'h8388: setup_d[1] = v;
        16'h8389: setup_d[2] = v;
        16'h838A: setup_d[3] = v;
        16'h838B: setup_d[4] = v;
        16'hF388: setup_d[5] = v;
        16'hF389: setup_d[6] = v;
        16'hF38A: setup_d[7] = v;
        16'hF38B: setup_d[8] = v;
        16'hF788: setup_d[9] = v;
        16'hF789: setup_d[10] = v;
        16'hFB8A: setup_d[11] = v;
        default: ;
      endcase
    end

    if (rd) begin
      if (tmr_sel) res.rd = trd;
      else begin
        case (a)
          16'h0B88: res.rd = mixer_q;
          16'h0B89: res.rd = status_q;
          16'h0B8A: res.rd = filter_q;
          16'h0B8B: res.rd = {3'b001, mask_q[4:0]};
          16'h0F8A: res.rd = pcmctl_q;
          16'h2789: res.rd = 8'h00;
          16'h7F89: res.rd = {setup_q[0][7:1], 1'b0};
          16'h8388: res.rd = setup_q[1];
          16'h8389: res.rd = setup_q[2];
          16'h838B: res.rd = setup_q[3];
          16'h838C: res.rd = setup_q[4];
          16'hEF8B: res.rd = 8'h0C;
          16'hF388: res.rd = setup_q[5];
          16'hF389: res.rd = setup_q[6];
          16'hF38B: res.rd = setup_q[7];
          16'hF38C: res.rd = setup_q[8];
          16'hF788: res.rd = setup_q[9];
          16'hF789: res.rd = setup_q[10];
          16'hFB8A: res.rd = setup_q[11];
          16'hFF88: res.rd = 8'h04;
          16'hFF8B: res.rd = 8'h31;
          default:  res.rd = 8'hFF;
        endcase
      end
    end

    if (tsts.ch0_expired) begin
      status_d[2] = 1'b1;
      if (mask_q[2]) res.irq = 1'b1;
      if (tsts.ch1_running && pcmctl_q[6]) begin
        if (setup_q[2][2]) begin
          s = {dma_first_i, dma_second_i};
          res.used = 2'd2;
        end else begin
          s = {dma_first_i ^ 8'h80, 8'h00};
          res.used = 2'd1;
        end
        if (setup_q[2][4]) s[15] = ~s[15];
        if (pcmctl_q[5]) begin
          left_d = s; right_d = s;
        end else begin
          if (tog_q) right_d = s; else left_d = s;
          tog_d = ~tog_q;
        end
      end
      if (tsts.ch1_expired) begin
        status_d[3] = 1'b1;
        if (mask_q[3]) res.irq = 1'b1;
      end
    end

    res.left  = filter_d[5] ? left_d  : 16'h0;
    res.right = filter_d[5] ? right_d : 16'h0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mixer_q <= '0; status_q <= '0; filter_q <= '0; mask_q <= '0;
      pcmctl_q <= '0; direct_q <= '0; left_q <= '0; right_q <= '0;
      tog_q <= 1'b0;
      for (int k = 0; k < 12; k++) setup_q[k] <= '0;
      o_vld_q <= 1'b0;
      sk_vld_q <= 1'b0;
      o_q <= '0;
      sk_q <= '0;
    end else begin
      mixer_q <= mixer_d; status_q <= status_d; filter_q <= filter_d;
      mask_q <= mask_d; pcmctl_q <= pcmctl_d; direct_q <= direct_d;
      left_q <= left_d; right_q <= right_d; tog_q <= tog_d;
      setup_q <= setup_d;
      // Output register with a skid stage behind it.
      if (!o_vld_q || !out_stall_i) begin
        if (sk_vld_q) begin
          o_vld_q  <= 1'b1;
          o_q      <= sk_q;
          sk_vld_q <= acc;
          sk_q     <= res;
        end else begin
          o_vld_q <= acc;
          if (acc) o_q <= res;
        end
      end else if (acc) begin
        sk_vld_q <= 1'b1;
        sk_q     <= res;
      end
    end
  end

  assign out_valid_o    = o_vld_q;
  assign read_byte_o    = o_q.rd;
  assign irq_pulse_o    = o_q.irq;
  assign dma_used_o     = o_q.used;
  assign left_sample_o  = o_q.left;
  assign right_sample_o = o_q.right;

`ifndef SYNTHESIS
  a_skid_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_vld_q |-> o_vld_q) else $error("skid holds data with empty output");
  a_fill_skid_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && out_stall_i && acc && !sk_vld_q) |=> sk_vld_q)
    else $error("beat lost on stall");
  a_used_needs_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.used != 2'd0) |-> tick) else $error("DMA used without tick");
`endif

endmodule
